### hdl/sat_restart_reduce_scheduler_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the restart / reduce scheduler
// Shared property shapes; the including module supplies clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef SAT_RESTART_REDUCE_SCHEDULER_UNIT_ASSERT_SVH
`define SAT_RESTART_REDUCE_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define SRRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define SRRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/srrs_pkg.sv
// ---------------------------------------------------------------------------
// srrs_pkg
// Types, widths and constants of the restart / reduce scheduler.
// ---------------------------------------------------------------------------
package srrs_pkg;

  // window and queue depths
  localparam int LBD_WINDOW   = 50;
  localparam int TRAIL_WINDOW = 5000;
  localparam int QUEUE_DEPTH  = 4;

  // field and counter widths
  localparam int LBD_W   = 16;
  localparam int TRAIL_W = 20;
  localparam int CNT_W   = 32;
  localparam int TOTAL_W = 48;
  localparam int RED_W   = 16;
  localparam int GAP_W   = 20;

  localparam int LADDR_W = $clog2(LBD_WINDOW);
  localparam int LFILL_W = $clog2(LBD_WINDOW + 1);
  localparam int LSUM_W  = LBD_W + $clog2(LBD_WINDOW);
  localparam int TADDR_W = $clog2(TRAIL_WINDOW);
  localparam int TFILL_W = $clog2(TRAIL_WINDOW + 1);
  localparam int TSUM_W  = TRAIL_W + $clog2(TRAIL_WINDOW);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  // restart test: 4*sum*cnt > (5*LBD_WINDOW)*total
  localparam int RESTART_K  = 5 * LBD_WINDOW;
  localparam int RSTP_W     = LSUM_W + CNT_W;
  localparam int RST_RHS_W  = TOTAL_W + $clog2(RESTART_K + 1);
  localparam int RST_CMP_W  = (RSTP_W + 2 > RST_RHS_W) ? RSTP_W + 2 : RST_RHS_W;

  // blocking test: trail*(5*fill) + 7*old > 7*(sum + trail)
  localparam int BLK_MUL_W  = TRAIL_W + TFILL_W + 3;
  localparam int BLK_RHS_W  = TSUM_W + 4;
  localparam int BLK_CMP_W  = (BLK_MUL_W + 1 > BLK_RHS_W) ? BLK_MUL_W + 1 : BLK_RHS_W;

  // next reduce mark: cnt + base_gap + step*reductions
  localparam int GPROD_W = GAP_W + RED_W;
  localparam int MBASE_W = CNT_W + 1;
  localparam int MARK_W  = ((MBASE_W > GPROD_W) ? MBASE_W : GPROD_W) + 1;

  // ports
  localparam int IN_TDATA_W  = ((LBD_W + TRAIL_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int OUT_RESTART_BIT = 0;
  localparam int OUT_REDUCE_BIT  = 1;
  localparam int OUT_BLOCKED_BIT = 2;

  // register reset values
  localparam logic [CNT_W-1:0] BLOCK_MIN_RST  = CNT_W'(10000);
  localparam logic [CNT_W-1:0] FIRST_MARK_RST = CNT_W'(2000);
  localparam logic [GAP_W-1:0] BASE_GAP_RST   = GAP_W'(2000);
  localparam logic [GAP_W-1:0] GAP_STEP_RST   = GAP_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_MIN  = 2'd0,
    REG_FIRST_MARK = 2'd1,
    REG_BASE_GAP   = 2'd2,
    REG_GAP_STEP   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_CONFLICT = 1'b0,
    OP_DECIDE   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [LBD_W-1:0]   lbd;
    logic [TRAIL_W-1:0] trail;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] block_min;
    logic [CNT_W-1:0] first_mark;
    logic [GAP_W-1:0] base_gap;
    logic [GAP_W-1:0] gap_step;
    logic             load_mark;
  } cfg_t;

endpackage

### hdl/srrs_front.sv
// ---------------------------------------------------------------------------
// srrs_front
// Input side: takes requests, decodes the command, buffers them in a
// small queue for the execution side.
// ---------------------------------------------------------------------------
module srrs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [srrs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [srrs_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              q_valid,
  input  logic                              q_ready,
  output srrs_pkg::req_t                    q_req
);
  import srrs_pkg::*;

  req_t              qmem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;
  req_t              req_in;

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_req     = qmem_r[rd_ptr_r];

  assign push = in_tvalid && in_tready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    req_in.op    = in_tuser[0] ? OP_DECIDE : OP_CONFLICT;
    req_in.lbd   = in_tdata[LBD_W-1:0];
    req_in.trail = in_tdata[LBD_W +: TRAIL_W];
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wr_ptr_r] <= req_in;
    end
  end

endmodule

### hdl/srrs_back.sv
// ---------------------------------------------------------------------------
// srrs_back
// Execution side: both moving windows, counters, restart / block / reduce
// decisions and the result register; no new request is taken until the last one finishes.
// ---------------------------------------------------------------------------
`include "sat_restart_reduce_scheduler_unit_assert.svh"

module srrs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srrs_pkg::cfg_t                    cfg,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  srrs_pkg::req_t                    q_req,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [srrs_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import srrs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // window memories
  logic [TRAIL_W-1:0] tmem [TRAIL_WINDOW];
  logic [LBD_W-1:0]   lmem [LBD_WINDOW];
  logic [TRAIL_W-1:0] t_old_r;
  logic [LBD_W-1:0]   l_old_r;

  // architectural state
  logic [TADDR_W-1:0] t_head_r, t_head_nxt;
  logic [TFILL_W-1:0] t_fill_r, t_fill_nxt;
  logic [TSUM_W-1:0]  t_sum_r, t_sum_nxt;
  logic [LADDR_W-1:0] l_head_r, l_head_nxt;
  logic [LFILL_W-1:0] l_fill_r, l_fill_nxt;
  logic [LSUM_W-1:0]  l_sum_r, l_sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   mark_r, mark_nxt;
  logic [RED_W-1:0]   red_r, red_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // pop-step results, held for the finish step (ST_FIN)
  op_t                op_r;
  logic [LBD_W-1:0]   lbd_r;
  logic               t_full_r;
  logic [BLK_MUL_W-1:0] blk_prod_r;
  logic [BLK_RHS_W-1:0] blk_rhs_r;
  logic [TSUM_W:0]    t_base_r;
  logic [RSTP_W-1:0]  rst_prod_r;
  logic [RST_RHS_W-1:0] rst_rhs_r;
  logic [RED_W-1:0]   red_inc_r;
  logic [GPROD_W-1:0] gap_prod_r;
  logic [MBASE_W-1:0] mark_base_r;
  logic               mark_due_r;

  // pop-step logic (ST_IDLE)
  logic               pop, t_we, t_full;
  logic [TFILL_W-1:0] t_fill_new;
  logic [TFILL_W+2:0] t_fill5;
  logic [TSUM_W:0]    t_base;
  logic [TADDR_W-1:0] t_head_inc;
  logic [CNT_W-1:0]   cnt_inc;
  logic [RED_W-1:0]   red_inc;

  // finish-step logic (ST_FIN)
  logic               out_free, l_full, l_we;
  logic [LADDR_W-1:0] l_waddr, l_head_inc;
  logic [TRAIL_W-1:0] t_old_m;
  logic [TRAIL_W+2:0] old7;
  logic [BLK_CMP_W-1:0] blk_lhs;
  logic               blk_hit, rst_hit;
  logic [TOTAL_W:0]   total_sum;
  logic [MARK_W-1:0]  mark_sum;
  logic [CNT_W-1:0]   mark_sat;
  logic               restart, reduce, blocked;

  assign q_ready    = (state_r == ST_IDLE);
  assign pop        = q_ready && q_valid;
  assign t_we       = pop && (q_req.op == OP_CONFLICT);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- pop step: memory reads, products, trail push bookkeeping ----
  assign t_full     = (t_fill_r == TFILL_W'(TRAIL_WINDOW));
  assign t_fill_new = t_full ? t_fill_r : t_fill_r + TFILL_W'(1);
  assign t_fill5    = ((TFILL_W+3)'(t_fill_new) << 2) + (TFILL_W+3)'(t_fill_new);
  assign t_base     = (TSUM_W+1)'(t_sum_r) + (TSUM_W+1)'(q_req.trail);
  assign t_head_inc = (t_head_r == TADDR_W'(TRAIL_WINDOW - 1)) ? '0
                                                               : t_head_r + TADDR_W'(1);
  assign cnt_inc    = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);
  assign red_inc    = (red_r == '1) ? red_r : red_r + RED_W'(1);

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r        <= q_req.op;
      lbd_r       <= q_req.lbd;
      t_full_r    <= t_full;
      blk_prod_r  <= BLK_MUL_W'(q_req.trail) * BLK_MUL_W'(t_fill5);
      blk_rhs_r   <= (BLK_RHS_W'(t_base) << 3) - BLK_RHS_W'(t_base);
      t_base_r    <= t_base;
      rst_prod_r  <= RSTP_W'(l_sum_r) * RSTP_W'(cnt_r);
      rst_rhs_r   <= RST_RHS_W'(total_r) * RST_RHS_W'(RESTART_K);
      red_inc_r   <= red_inc;
      gap_prod_r  <= GPROD_W'(cfg.gap_step) * GPROD_W'(red_inc);
      mark_base_r <= MBASE_W'(cnt_r) + MBASE_W'(cfg.base_gap);
      mark_due_r  <= (cnt_r >= mark_r);
    end
  end

  // trail window: read-before-write at the head
  always_ff @(posedge clk) begin
    if (pop) begin
      t_old_r <= tmem[t_head_r];
    end
    if (t_we) begin
      tmem[t_head_r] <= q_req.trail;
    end
  end

  // lbd window: read at pop, written at finish
  always_ff @(posedge clk) begin
    if (pop) begin
      l_old_r <= lmem[l_head_r];
    end
    if (l_we) begin
      lmem[l_waddr] <= lbd_r;
    end
  end

  // ---- finish step (ST_FIN): compares and updates ----
  assign t_old_m    = t_full_r ? t_old_r : '0;
  assign old7       = ((TRAIL_W+3)'(t_old_m) << 3) - (TRAIL_W+3)'(t_old_m);
  assign blk_lhs    = BLK_CMP_W'(blk_prod_r) + BLK_CMP_W'(old7);
  assign l_full     = (l_fill_r == LFILL_W'(LBD_WINDOW));
  assign blk_hit    = (cnt_r > cfg.block_min) && l_full && (blk_lhs > BLK_CMP_W'(blk_rhs_r));
  assign rst_hit    = l_full && ((RST_CMP_W'(rst_prod_r) << 2) > RST_CMP_W'(rst_rhs_r));
  assign l_head_inc = (l_head_r == LADDR_W'(LBD_WINDOW - 1)) ? '0 : l_head_r + LADDR_W'(1);
  assign total_sum  = (TOTAL_W+1)'(total_r) + (TOTAL_W+1)'(lbd_r);
  assign mark_sum   = MARK_W'(mark_base_r) + MARK_W'(gap_prod_r);
  assign mark_sat   = (mark_sum[MARK_W-1:CNT_W] != '0) ? '1 : mark_sum[CNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    t_head_nxt    = t_head_r;
    t_fill_nxt    = t_fill_r;
    t_sum_nxt     = t_sum_r;
    l_head_nxt    = l_head_r;
    l_fill_nxt    = l_fill_r;
    l_sum_nxt     = l_sum_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    mark_nxt      = mark_r;
    red_nxt       = red_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    l_we          = 1'b0;
    l_waddr       = l_head_r;
    restart       = 1'b0;
    reduce        = 1'b0;
    blocked       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_FIN;
          if (q_req.op == OP_CONFLICT) begin
            cnt_nxt    = cnt_inc;
            t_head_nxt = t_head_inc;
            t_fill_nxt = t_fill_new;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (op_r == OP_CONFLICT) begin
            t_sum_nxt = TSUM_W'(t_base_r - (TSUM_W+1)'(t_old_m));
            total_nxt = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            l_we      = 1'b1;
            blocked   = blk_hit;
            if (blk_hit) begin
              // window cleared, this lbd becomes its only entry
              l_waddr    = '0;
              l_head_nxt = LADDR_W'(1);
              l_fill_nxt = LFILL_W'(1);
              l_sum_nxt  = LSUM_W'(lbd_r);
            end else begin
              l_head_nxt = l_head_inc;
              if (l_full) begin
                l_sum_nxt = l_sum_r - LSUM_W'(l_old_r) + LSUM_W'(lbd_r);
              end else begin
                l_fill_nxt = l_fill_r + LFILL_W'(1);
                l_sum_nxt  = l_sum_r + LSUM_W'(lbd_r);
              end
            end
          end else begin
            if (rst_hit) begin
              restart    = 1'b1;
              l_head_nxt = '0;
              l_fill_nxt = '0;
              l_sum_nxt  = '0;
            end else if (mark_due_r) begin
              reduce   = 1'b1;
              red_nxt  = red_inc_r;
              mark_nxt = mark_sat;
            end
          end
          out_data_nxt                  = '0;
          out_data_nxt[OUT_RESTART_BIT] = restart;
          out_data_nxt[OUT_REDUCE_BIT]  = reduce;
          out_data_nxt[OUT_BLOCKED_BIT] = blocked;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg.load_mark) begin
      mark_nxt = cfg.first_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      t_head_r    <= '0;
      t_fill_r    <= '0;
      t_sum_r     <= '0;
      l_head_r    <= '0;
      l_fill_r    <= '0;
      l_sum_r     <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      mark_r      <= FIRST_MARK_RST;
      red_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      t_head_r    <= t_head_nxt;
      t_fill_r    <= t_fill_nxt;
      t_sum_r     <= t_sum_nxt;
      l_head_r    <= l_head_nxt;
      l_fill_r    <= l_fill_nxt;
      l_sum_r     <= l_sum_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      mark_r      <= mark_nxt;
      red_r       <= red_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // ---- checks ----
  `SRRS_ASSERT_IMP(a_lbd_head_fill, l_fill_r < LFILL_W'(LBD_WINDOW), LFILL_W'(l_head_r) == l_fill_r, "lbd head out of step with fill")
  `SRRS_ASSERT_IMP(a_trail_head_fill, t_fill_r < TFILL_W'(TRAIL_WINDOW), TFILL_W'(t_head_r) == t_fill_r, "trail head out of step with fill")
  `SRRS_ASSERT_NXT(a_pop_to_finish, pop, state_r == ST_FIN, "request taken without finish cycle")
  `SRRS_ASSERT_IMP(a_single_flag, out_valid_r, $countones(out_data_r) <= 1, "more than one result flag set")

endmodule

### hdl/sat_restart_reduce_scheduler_unit.sv
// ---------------------------------------------------------------------------
// sat_restart_reduce_scheduler_unit
// Restart, restart-blocking and learnt-database reduction policy of a
// conflict-driven search, driven by moving LBD and trail averages.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------
//  in_     | in  | in_tvalid/in_tready | tuser: command; tdata: lbd, trail_size
//  out_    | out | out_tvalid/tready   | tdata: restart, reduce_db, restart_blocked
//  cfg_    | in  | cfg_we              | cfg_index selects register, cfg_wdata
//
//  In the execution side each request first reads both window memories at
//  their heads and forms the products, then compares and updates the
//  windows; the next request waits until that read-modify-write is done.
//  Requests are taken every cycle while the 4-entry queue has room.
//  A request passes the queue, both execution steps and the result register
//  on its way out; a stalled result holds the execution side once its
//  result register is full. rst_n is synchronous, active low; counters
//  and window fill/head/sum clear; window memories are not (fill counts guard).
// ---------------------------------------------------------------------------
module sat_restart_reduce_scheduler_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // command request
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [srrs_pkg::IN_TDATA_W-1:0]    in_tdata,  // [15:0] lbd, [35:16] trail_size
  input  logic [srrs_pkg::IN_TUSER_W-1:0]    in_tuser,  // [0] command (1 = decision)
  // result request
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [srrs_pkg::OUT_TDATA_W-1:0]   out_tdata, // [0] restart, [1] reduce_db,
                                                        // [2] restart_blocked
  // register writes
  input  logic                               cfg_we,
  input  logic [srrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srrs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import srrs_pkg::*;

  logic [CNT_W-1:0] block_min_r;
  logic [GAP_W-1:0] base_gap_r;
  logic [GAP_W-1:0] gap_step_r;
  cfg_t             cfg;

  logic             q_valid;
  logic             q_ready;
  req_t             q_req;

  // register file; the first mark has no copy here, a write to it
  // reloads the live mark in the back end straight from the write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_min_r  <= BLOCK_MIN_RST;
      base_gap_r   <= BASE_GAP_RST;
      gap_step_r   <= GAP_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLOCK_MIN:  block_min_r  <= cfg_wdata[CNT_W-1:0];
        REG_FIRST_MARK: ;
        REG_BASE_GAP:   base_gap_r   <= cfg_wdata[GAP_W-1:0];
        REG_GAP_STEP:   gap_step_r   <= cfg_wdata[GAP_W-1:0];
      endcase
    end
  end

  always_comb begin
    cfg.block_min  = block_min_r;
    cfg.first_mark = cfg_wdata[CNT_W-1:0];
    cfg.base_gap   = base_gap_r;
    cfg.gap_step   = gap_step_r;
    cfg.load_mark  = cfg_we && (cfg_reg_t'(cfg_index) == REG_FIRST_MARK);
  end

  srrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req)
  );

  srrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### test/srrs_checker.sv
// ---------------------------------------------------------------------------
// srrs_checker
// Watches the request, result and register-write ports of the restart /
// reduce scheduler, predicts each result and compares it field by field.
// ---------------------------------------------------------------------------
module srrs_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [srrs_pkg::IN_TDATA_W-1:0]  in_tdata,  // [15:0] lbd, [35:16] trail_size
  input  logic [srrs_pkg::IN_TUSER_W-1:0]  in_tuser,  // [0] command
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [srrs_pkg::OUT_TDATA_W-1:0] out_tdata, // [0] restart, [1] reduce_db,
                                                      // [2] restart_blocked
  input  logic                             cfg_we,
  input  logic [srrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               fails,
  output int                               pending
);
  import srrs_pkg::*;

  localparam logic [63:0] CNT_SAT   = 64'hFFFF_FFFF;
  localparam logic [63:0] TOTAL_SAT = 64'hFFFF_FFFF_FFFF;

  // register file copy
  logic [CNT_W-1:0]   block_min;
  logic [CNT_W-1:0]   first_mark;
  logic [GAP_W-1:0]   base_gap;
  logic [GAP_W-1:0]   gap_step;

  // policy state
  logic [LBD_W-1:0]   lbd_hist   [LBD_WINDOW];
  logic [TRAIL_W-1:0] trail_hist [TRAIL_WINDOW];
  int unsigned        lbd_fill, lbd_head, trail_fill, trail_head;
  logic [63:0]        lbd_sum, trail_sum, lbd_total;
  logic [CNT_W-1:0]   conflicts;
  logic [CNT_W-1:0]   reduce_mark;
  logic [RED_W-1:0]   reductions;

  // flags vectors use the result bit positions
  logic [2:0]         flags_due [$];
  int                 fail_cnt = 0;
  int                 results_seen = 0;
  string              field_tag [3] = '{"restart", "reduce_db", "restart_blocked"};

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic load_defaults();
    block_min   = 32'd10000;
    first_mark  = 32'd2000;
    base_gap    = 20'd2000;
    gap_step    = 20'd1000;
    lbd_fill    = 0;
    lbd_head    = 0;
    lbd_sum     = '0;
    trail_fill  = 0;
    trail_head  = 0;
    trail_sum   = '0;
    lbd_total   = '0;
    conflicts   = '0;
    reduce_mark = 32'd2000;
    reductions  = '0;
  endtask

  task automatic drop_lbd_window();
    lbd_fill = 0;
    lbd_head = 0;
    lbd_sum  = '0;
  endtask

  task automatic predict_sched_flags(input op_t op, input logic [LBD_W-1:0] lbd,
                                     input logic [TRAIL_W-1:0] trail,
                                     output logic [2:0] flags);
    logic [63:0] mark;
    flags = '0;
    if (op == OP_CONFLICT) begin
      if (conflicts != '1) conflicts = conflicts + 1'b1;
      // trail moving window, evict oldest once full
      if (trail_fill == TRAIL_WINDOW) trail_sum = trail_sum - trail_hist[trail_head];
      else trail_fill++;
      trail_hist[trail_head] = trail;
      trail_sum  = trail_sum + trail;
      trail_head = (trail_head + 1 == TRAIL_WINDOW) ? 0 : trail_head + 1;
      // blocking: deep trail vs. 1.4x average
      if (conflicts > block_min && lbd_fill == LBD_WINDOW &&
          64'(trail) * 5 * trail_fill > 7 * trail_sum) begin
        drop_lbd_window();
        flags[OUT_BLOCKED_BIT] = 1'b1;
      end
      if (lbd_fill == LBD_WINDOW) lbd_sum = lbd_sum - lbd_hist[lbd_head];
      else lbd_fill++;
      lbd_hist[lbd_head] = lbd;
      lbd_sum   = lbd_sum + lbd;
      lbd_head  = (lbd_head + 1 == LBD_WINDOW) ? 0 : lbd_head + 1;
      lbd_total = (lbd_total + lbd > TOTAL_SAT) ? TOTAL_SAT : lbd_total + lbd;
    end else begin
      // restart: recent average above 1.25x global (0.8 factor)
      if (lbd_fill == LBD_WINDOW &&
          4 * lbd_sum * 64'(conflicts) > 5 * LBD_WINDOW * lbd_total) begin
        drop_lbd_window();
        flags[OUT_RESTART_BIT] = 1'b1;
      end else if (conflicts >= reduce_mark) begin
        flags[OUT_REDUCE_BIT] = 1'b1;
        if (reductions != '1) reductions = reductions + 1'b1;
        mark = 64'(conflicts) + 64'(base_gap) + 64'(gap_step) * 64'(reductions);
        reduce_mark = (mark > CNT_SAT) ? '1 : mark[CNT_W-1:0];
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    logic [2:0] got, want;
    if (!rst_n) begin
      load_defaults();
      flags_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[2:0];
        results_seen++;
        if (flags_due.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = flags_due.pop_front();
          for (int i = 0; i < 3; i++)
            if (got[i] !== want[i])
              report($sformatf("result %0d %s expected %0b got %0b",
                               results_seen, field_tag[i], want[i], got[i]));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_MIN:  block_min = cfg_wdata;
          REG_FIRST_MARK: begin
            first_mark  = cfg_wdata;
            reduce_mark = cfg_wdata;   // write also rearms the next mark
          end
          REG_BASE_GAP:   base_gap = cfg_wdata[GAP_W-1:0];
          REG_GAP_STEP:   gap_step = cfg_wdata[GAP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_sched_flags(op_t'(in_tuser[0]), in_tdata[LBD_W-1:0],
                            in_tdata[LBD_W +: TRAIL_W], want);
        flags_due.push_back(want);
      end
    end
    pending <= flags_due.size();
    fails   <= fail_cnt;
  end

endmodule

### test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives conflict and decision requests plus register writes into the
// restart / reduce scheduler; the checker predicts and compares results.
// ---------------------------------------------------------------------------
module testbench;
  import srrs_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] lbd, [35:16] trail_size
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // [0] command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [0] restart, [1] reduce_db, [2] restart_blocked
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int fails;
  int pending;

  // idling switch shared by sender and receiver
  bit idle_on = 1'b1;
  // current LBD / trail "regime" of the random stream
  int lbd_level = 4;
  int trail_level = 500;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sat_restart_reduce_scheduler_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  srrs_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fails      (fails),
    .pending    (pending)
  );

  // Result side: random stall bursts while idling is on.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Watchdog: no request or result moved for too long means a hang.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) quiet++;
      else quiet = 0;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // One request. Entered and left at a falling edge; valid stays high on
  // return, so back-to-back requests drop it only for a random idle gap.
  task automatic push_req(input op_t op, input logic [LBD_W-1:0] lbd,
                          input logic [TRAIL_W-1:0] trail);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = IN_TDATA_W'({trail, lbd});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every result is back; the short pause
  // lets the pipe settle before a register is touched.
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Mostly regime-shaped traffic (runs of similar LBD and trail depth, so
  // the windows fill and averages drift), with spikes and raw noise.
  task automatic random_req(input int decide_odds);
    op_t                op;
    logic [LBD_W-1:0]   lbd;
    logic [TRAIL_W-1:0] trail;
    if ($urandom_range(0, 59) == 0) begin
      lbd_level   = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 200)
                                                : $urandom_range(2, 12);
      trail_level = $urandom_range(50, 5000);
    end
    op = ($urandom_range(1, decide_odds) == 1) ? OP_DECIDE : OP_CONFLICT;
    case ($urandom_range(0, 19))
      0: begin      // noise over the full field range
        lbd   = LBD_W'($urandom);
        trail = TRAIL_W'($urandom);
      end
      1, 2: begin   // deep trail / bad clause spike
        lbd   = LBD_W'(lbd_level * 2 + $urandom_range(0, lbd_level));
        trail = TRAIL_W'(trail_level * 2 + $urandom_range(0, trail_level));
      end
      default: begin
        lbd   = LBD_W'(lbd_level + $urandom_range(0, lbd_level / 4));
        trail = TRAIL_W'(trail_level + $urandom_range(0, trail_level / 8));
      end
    endcase
    push_req(op, lbd, trail);
  endtask

  initial begin : stimulus
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // decision with zero conflicts: no restart, mark not reached,
    // and the ignored fields at all-ones
    push_req(OP_DECIDE, '1, '1);
    push_req(OP_CONFLICT, '0, '0);
    push_req(OP_CONFLICT, '1, '1);
    push_req(OP_CONFLICT, 16'd1, 20'd1);
    push_req(OP_CONFLICT, 16'h5555, 20'hAAAAA);
    push_req(OP_CONFLICT, 16'hAAAA, 20'h55555);
    push_req(OP_DECIDE, '0, '0);
    drain();
    // rearm the first mark at zero: next decision reduces, the one after
    // sits below the new mark
    write_reg(REG_FIRST_MARK, '0);
    push_req(OP_DECIDE, 16'h1234, 20'h56789);
    push_req(OP_DECIDE, '0, '0);
    push_req(OP_CONFLICT, 16'd3, 20'd100);
    push_req(OP_DECIDE, '1, '0);

    // --- small thresholds: blocking and reductions come early ---
    drain();
    write_reg(REG_BLOCK_MIN, 32'd40);
    write_reg(REG_FIRST_MARK, 32'd60);
    write_reg(REG_BASE_GAP, 32'd30);
    write_reg(REG_GAP_STEP, 32'd7);
    repeat (120) random_req(8);

    // --- extremes: blocking possible from the first conflict, reductions never due;
    //     upper write bits of the gap registers are dropped ---
    drain();
    write_reg(REG_BLOCK_MIN, '0);
    write_reg(REG_FIRST_MARK, '1);
    write_reg(REG_BASE_GAP, '1);
    write_reg(REG_GAP_STEP, '1);
    repeat (100) random_req(6);

    // --- no blocking, every decision due: restarts against reductions ---
    drain();
    idle_on = 1'b0;
    write_reg(REG_BLOCK_MIN, '1);
    write_reg(REG_FIRST_MARK, '0);
    write_reg(REG_BASE_GAP, '0);
    write_reg(REG_GAP_STEP, '0);
    repeat (60) random_req(5);

    // --- moderate thresholds, mixed traffic ---
    drain();
    write_reg(REG_BLOCK_MIN, 32'd100);
    write_reg(REG_FIRST_MARK, 32'd500);
    write_reg(REG_BASE_GAP, 32'd300);
    write_reg(REG_GAP_STEP, 32'd50);
    repeat (60) random_req(16);

    // --- decisions back to back with every one due, then widest gaps ---
    drain();
    write_reg(REG_FIRST_MARK, '0);
    write_reg(REG_BASE_GAP, '0);
    write_reg(REG_GAP_STEP, '0);
    repeat (20) push_req(OP_DECIDE, LBD_W'($urandom), TRAIL_W'($urandom));
    drain();
    write_reg(REG_BASE_GAP, 32'h000F_FFFF);
    write_reg(REG_GAP_STEP, 32'h000F_FFFF);
    push_req(OP_DECIDE, '0, '0);
    push_req(OP_DECIDE, '0, '0);
    repeat (20) random_req(8);

    drain();
    repeat (8) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
